// ===== rtl/ufk_pkg.sv =====
// Shared constants for the union-find edge filter.
`default_nettype none

package ufk_pkg;

  localparam int VERTICES_DEF = 256;
  localparam int RANK_W       = 4;
  localparam int COST_W       = 32;
  localparam int VTX_IN_W     = 8;
  localparam int WEIGHT_W     = 16;
  localparam int ROOT_OUT_W   = 8;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [COST_W-1:0] COST_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_FIND  = 2'd1;
  localparam logic [1:0] CMD_EDGE  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/union_find_kruskal_edge_filter_top.sv =====
// Top level of the union-find engine that filters Kruskal edges.
`default_nettype none

//  Channel   Ports                                              Handshake
//  command   in_command, in_vertex_a, in_vertex_b, in_weight   start & !busy
//  result    out_root, out_accepted, out_total_cost            out_valid, one cycle
//
// A find transaction keeps busy high while it walks from vertex_a up to its root;
// each table entry visited takes one registered read followed by one compare.
// An offer-edge transaction walks both endpoints the same way and then spends
// one merge step, plus one rank step when equal ranks force a rank increment.
// Under union by rank a walk visits at most log2(VERTICES)+1 entries.
// A clear transaction sweeps the table one entry per cycle and then presents
// its result. After reset the same sweep runs (busy high, no result) before
// the first transaction is taken.
// Results cannot be stalled: out_valid is high for exactly one cycle per
// transaction, in the cycle in which busy first reads low again. An unused
// command code never raises busy and is answered in the cycle after it is taken.

module union_find_kruskal_edge_filter_top
  import ufk_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_command,
  input  wire logic [VTX_IN_W-1:0]   in_vertex_a,
  input  wire logic [VTX_IN_W-1:0]   in_vertex_b,
  input  wire logic [WEIGHT_W-1:0]   in_weight,
  output logic                       out_valid,
  output logic [ROOT_OUT_W-1:0]      out_root,
  output logic                       out_accepted,
  output logic [COST_W-1:0]          out_total_cost
);

  // Vertex index width; each table word holds a rank above a parent index.
  localparam int VW = $clog2(VERTICES);
  localparam int DW = VW + RANK_W;
  // Number of distinct vertex codes on an input port.
  localparam int VTX_CODES = 1 << VTX_IN_W;

  logic [VTX_CODES*VW-1:0] vtx_map;
  logic [VW-1:0] va_red;
  logic [VW-1:0] vb_red;
  logic          mem_we;
  logic [VW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [VW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  // Incoming vertex numbers wrap around the table size, so an index at or
  // above VERTICES lands on its remainder. The remainders form a constant
  // lookup table with one entry per input code, fixed at elaboration.
  for (genvar gi = 0; gi < VTX_CODES; gi++) begin : g_vtx_map
    assign vtx_map[gi*VW +: VW] = VW'(gi % VERTICES);
  end

  assign va_red = vtx_map[int'(in_vertex_a) * VW +: VW];
  assign vb_red = vtx_map[int'(in_vertex_b) * VW +: VW];

  ufk_seq #(
    .VERTICES (VERTICES),
    .VW       (VW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (in_command),
    .va           (va_red),
    .vb           (vb_red),
    .weight       (in_weight),
    .res_valid    (out_valid),
    .res_root     (out_root),
    .res_accepted (out_accepted),
    .res_cost     (out_total_cost),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Rank and parent of every vertex share one word of this table.
  ufk_mem #(
    .DEPTH (VERTICES),
    .AW    (VW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/ufk_mem.sv =====
// Single-port-write, registered-read table holding rank and parent per vertex.
`default_nettype none

module ufk_mem
  import ufk_pkg::*;
#(
  parameter int DEPTH = VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = AW + RANK_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/ufk_seq.sv =====
// Sequencer for table clearing, root walks, union by rank and cost update.
`default_nettype none

module ufk_seq
  import ufk_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF,
  parameter int VW       = $clog2(VERTICES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               cmd,
  input  wire logic [VW-1:0]            va,
  input  wire logic [VW-1:0]            vb,
  input  wire logic [WEIGHT_W-1:0]      weight,
  output logic                          res_valid,
  output logic [ROOT_OUT_W-1:0]         res_root,
  output logic                          res_accepted,
  output logic [COST_W-1:0]             res_cost,
  output logic                          mem_we,
  output logic [VW-1:0]                 mem_waddr,
  output logic [VW+RANK_W-1:0]          mem_wdata,
  output logic [VW-1:0]                 mem_raddr,
  input  wire logic [VW+RANK_W-1:0]     mem_rdata
);

  localparam int RootW = (VW > ROOT_OUT_W) ? VW : ROOT_OUT_W;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RDA, S_CKA, S_RDB, S_CKB, S_MERGE, S_RANK
  } state_t;

  state_t                state_r;
  logic [VW-1:0]         cnt_r;
  logic                  clr_out_r;
  logic [1:0]            cmd_r;
  logic [VW-1:0]         vb_r;
  logic [WEIGHT_W-1:0]   weight_r;
  logic [VW-1:0]         cur_r;
  logic [VW-1:0]         ra_r;
  logic [VW-1:0]         rb_r;
  logic [RANK_W-1:0]     rank_a_r;
  logic [RANK_W-1:0]     rank_b_r;
  logic [COST_W-1:0]     cost_r;
  logic                  out_valid_r;
  logic [ROOT_OUT_W-1:0] out_root_r;
  logic                  out_acc_r;
  logic [COST_W-1:0]     out_cost_r;

  logic [VW-1:0]         rd_parent;
  logic [RANK_W-1:0]     rd_rank;
  logic                  at_root;
  logic [COST_W:0]       cost_sum;
  logic [COST_W-1:0]     cost_nxt;
  logic [RANK_W-1:0]     rank_inc;
  logic [RootW-1:0]      ra_ext;
  logic [RootW-1:0]      rb_ext;
  logic [RootW-1:0]      cur_ext;

  assign rd_parent = mem_rdata[VW-1:0];
  assign rd_rank   = mem_rdata[VW+RANK_W-1:VW];
  // The single comparator shared by both root walks.
  assign at_root   = (rd_parent == cur_r);

  assign cost_sum = {1'b0, cost_r} + (COST_W+1)'(weight_r);
  assign cost_nxt = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
  assign rank_inc = (rank_a_r == RANK_MAX) ? RANK_MAX : rank_a_r + 1'b1;

  assign ra_ext  = RootW'(ra_r);
  assign rb_ext  = RootW'(rb_r);
  assign cur_ext = RootW'(cur_r);

  assign busy      = (state_r != S_IDLE);
  assign mem_raddr = cur_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = {{RANK_W{1'b0}}, cnt_r};
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_MERGE: begin
        mem_we = (ra_r != rb_r);
        if (rank_a_r >= rank_b_r) begin
          mem_waddr = rb_r;
          mem_wdata = {rank_b_r, ra_r};
        end else begin
          mem_waddr = ra_r;
          mem_wdata = {rank_a_r, rb_r};
        end
      end
      S_RANK: begin
        mem_we    = 1'b1;
        mem_waddr = ra_r;
        mem_wdata = {rank_inc, ra_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_out_r   <= 1'b0;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          if (cnt_r == VW'(VERTICES - 1)) begin
            state_r <= S_IDLE;
            cost_r  <= '0;
            if (clr_out_r) begin
              out_valid_r <= 1'b1;
              out_root_r  <= '0;
              out_acc_r   <= 1'b0;
              out_cost_r  <= '0;
            end
            clr_out_r <= 1'b0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            cur_r    <= va;
            vb_r     <= vb;
            weight_r <= weight;
            case (cmd)
              CMD_CLEAR: begin
                state_r   <= S_CLR;
                cnt_r     <= '0;
                clr_out_r <= 1'b1;
              end
              CMD_FIND, CMD_EDGE: begin
                state_r <= S_RDA;
              end
              default: begin
                out_valid_r <= 1'b1;
                out_root_r  <= '0;
                out_acc_r   <= 1'b0;
                out_cost_r  <= cost_r;
              end
            endcase
          end
        end
        S_RDA: begin
          state_r <= S_CKA;
        end
        S_CKA: begin
          if (at_root) begin
            ra_r     <= cur_r;
            rank_a_r <= rd_rank;
            if (cmd_r == CMD_FIND) begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_root_r  <= cur_ext[ROOT_OUT_W-1:0];
              out_acc_r   <= 1'b0;
              out_cost_r  <= cost_r;
            end else begin
              cur_r   <= vb_r;
              state_r <= S_RDB;
            end
          end else begin
            cur_r   <= rd_parent;
            state_r <= S_RDA;
          end
        end
        S_RDB: begin
          state_r <= S_CKB;
        end
        S_CKB: begin
          if (at_root) begin
            rb_r     <= cur_r;
            rank_b_r <= rd_rank;
            state_r  <= S_MERGE;
          end else begin
            cur_r   <= rd_parent;
            state_r <= S_RDB;
          end
        end
        S_MERGE: begin
          if (ra_r == rb_r) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_root_r  <= ra_ext[ROOT_OUT_W-1:0];
            out_acc_r   <= 1'b0;
            out_cost_r  <= cost_r;
          end else begin
            cost_r <= cost_nxt;
            if (rank_a_r == rank_b_r) begin
              state_r <= S_RANK;
            end else begin
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
              out_root_r  <= (rank_a_r > rank_b_r) ? ra_ext[ROOT_OUT_W-1:0]
                                                   : rb_ext[ROOT_OUT_W-1:0];
              out_acc_r   <= 1'b1;
              out_cost_r  <= cost_nxt;
            end
          end
        end
        S_RANK: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          out_root_r  <= ra_ext[ROOT_OUT_W-1:0];
          out_acc_r   <= 1'b1;
          out_cost_r  <= cost_r;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid    = out_valid_r;
  assign res_root     = out_root_r;
  assign res_accepted = out_acc_r;
  assign res_cost     = out_cost_r;

endmodule

`default_nettype wire

// ===== tb/forest_checker.sv =====
// Checker that predicts every result of the union-find edge filter and compares it.
`timescale 1ns / 100ps

module forest_checker
  import ufk_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [VTX_IN_W-1:0]   in_vertex_a,
  input  logic [VTX_IN_W-1:0]   in_vertex_b,
  input  logic [WEIGHT_W-1:0]   in_weight,
  input  logic                  out_valid,
  input  logic [ROOT_OUT_W-1:0] out_root,
  input  logic                  out_accepted,
  input  logic [COST_W-1:0]     out_total_cost,
  output int                    fail_count,
  output int                    pending_count,
  output int                    joined_count,
  output int                    deepest_walk
);

  typedef struct packed {
    logic [ROOT_OUT_W-1:0] root;
    logic                  accepted;
    logic [COST_W-1:0]     total_cost;
  } forest_outcome_t;

  int                parent_of [VERTICES];
  logic [RANK_W-1:0] rank_of [VERTICES];
  logic [COST_W-1:0] tree_cost;
  int                failures = 0;
  int                joined = 0;
  int                deepest = 0;
  forest_outcome_t   outcomes_due [$];

  function automatic void wipe_forest();
    for (int i = 0; i < VERTICES; i++) begin
      parent_of[i] = i;
      rank_of[i] = '0;
    end
    tree_cost = '0;
  endfunction

  // Follows parent links up to the root, at most VERTICES links.
  function automatic int find_root(int v);
    int steps;
    steps = 0;
    while (steps < VERTICES && parent_of[v] != v) begin
      v = parent_of[v];
      steps++;
    end
    if (steps > deepest) deepest = steps;
    return v;
  endfunction

  function automatic forest_outcome_t apply_command(logic [1:0] cmd, logic [VTX_IN_W-1:0] va,
                                                    logic [VTX_IN_W-1:0] vb,
                                                    logic [WEIGHT_W-1:0] w);
    forest_outcome_t res;
    int a;
    int b;
    int ra;
    int rb;
    a = int'(va) % VERTICES;
    b = int'(vb) % VERTICES;
    res = '0;
    case (cmd)
      CMD_CLEAR: begin
        wipe_forest();
      end
      CMD_FIND: begin
        res.root = ROOT_OUT_W'(find_root(a));
      end
      CMD_EDGE: begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb) begin
          res.root = ROOT_OUT_W'(ra);
        end else begin
          res.accepted = 1'b1;
          joined++;
          if (tree_cost > COST_MAX - COST_W'(w)) tree_cost = COST_MAX;
          else tree_cost = tree_cost + COST_W'(w);
          if (rank_of[ra] == rank_of[rb]) begin
            parent_of[rb] = ra;
            if (rank_of[ra] < RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
            res.root = ROOT_OUT_W'(ra);
          end else if (rank_of[ra] > rank_of[rb]) begin
            parent_of[rb] = ra;
            res.root = ROOT_OUT_W'(ra);
          end else begin
            parent_of[ra] = rb;
            res.root = ROOT_OUT_W'(rb);
          end
        end
      end
      default: begin
      end
    endcase
    res.total_cost = tree_cost;
    return res;
  endfunction

  // Results are compared before the new transaction is predicted, since a
  // result and the next acceptance may share one clock edge.
  always @(posedge clk) begin
    forest_outcome_t due;
    if (!rst_n) begin
      wipe_forest();
      outcomes_due.delete();
    end else begin
      if (out_valid) begin
        if (outcomes_due.size() == 0) begin
          $error("result with no transaction waiting: root %0d accepted %0d cost %0d",
                 out_root, out_accepted, out_total_cost);
          failures++;
        end else begin
          due = outcomes_due.pop_front();
          if (out_root !== due.root) begin
            $error("root: expected %0d, got %0d", due.root, out_root);
            failures++;
          end
          if (out_accepted !== due.accepted) begin
            $error("accepted: expected %0d, got %0d", due.accepted, out_accepted);
            failures++;
          end
          if (out_total_cost !== due.total_cost) begin
            $error("total_cost: expected %0d, got %0d", due.total_cost, out_total_cost);
            failures++;
          end
        end
      end
      if (start && !busy) begin
        outcomes_due.insert(outcomes_due.size(),
                            apply_command(in_command, in_vertex_a, in_vertex_b, in_weight));
      end
    end
    fail_count    <= failures;
    pending_count <= outcomes_due.size();
    joined_count  <= joined;
    deepest_walk  <= deepest;
  end

endmodule

// ===== tb/union_find_kruskal_edge_filter_top_test.sv =====
// Stimulus and verdict for the union-find Kruskal edge filter, checked by forest_checker.
`timescale 1ns / 100ps

module union_find_kruskal_edge_filter_top_test;
  import ufk_pkg::*;

  // The fourth command encoding does nothing in the block but still answers.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_command;
  logic [VTX_IN_W-1:0]   in_vertex_a;
  logic [VTX_IN_W-1:0]   in_vertex_b;
  logic [WEIGHT_W-1:0]   in_weight;
  logic                  out_valid;
  logic [ROOT_OUT_W-1:0] out_root;
  logic                  out_accepted;
  logic [COST_W-1:0]     out_total_cost;

  int fail_count;
  int pending_count;
  int joined_count;
  int deepest_walk;

  // Percentage of cycles in which the sender holds start low before a transaction.
  int sender_idle_pct = 0;
  // Counters for the closing summary. Unused commands are not counted as items.
  int items_sent = 0;
  int clears_sent = 0;
  int finds_sent = 0;
  int edges_sent = 0;
  int unused_sent = 0;
  // Running weight of the current edge sequence, kept nondecreasing.
  logic [WEIGHT_W-1:0] edge_weight;

  always #5 clk = ~clk;

  union_find_kruskal_edge_filter_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_weight      (in_weight),
    .out_valid      (out_valid),
    .out_root       (out_root),
    .out_accepted   (out_accepted),
    .out_total_cost (out_total_cost)
  );

  forest_checker u_forest_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_weight      (in_weight),
    .out_valid      (out_valid),
    .out_root       (out_root),
    .out_accepted   (out_accepted),
    .out_total_cost (out_total_cost),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .joined_count   (joined_count),
    .deepest_walk   (deepest_walk)
  );

  // Presents one transaction and returns at the clock edge that accepts it.
  // Random idle cycles are inserted first, so gaps land at every point of the
  // block's work. Busy is read right after the edge, which gives the value it
  // had during the cycle that edge closes, so acceptance is seen exactly as
  // the block sees it. Start gets exactly one assignment per time step.
  task automatic send_cmd(input logic [1:0] cmd, input logic [VTX_IN_W-1:0] va,
                          input logic [VTX_IN_W-1:0] vb, input logic [WEIGHT_W-1:0] w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_command  <= cmd;
    in_vertex_a <= va;
    in_vertex_b <= vb;
    in_weight   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (cmd)
      CMD_CLEAR: clears_sent++;
      CMD_FIND:  finds_sent++;
      CMD_EDGE:  edges_sent++;
      default:   unused_sent++;
    endcase
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Scatters episode indexes over the whole vertex range. An odd stride
  // makes the mapping a permutation, so small pools still touch every bit.
  function automatic logic [VTX_IN_W-1:0] spread(int base, int stride, int idx);
    return VTX_IN_W'(base + idx * stride);
  endfunction

  // Offers one edge of the current sequence. Most weights climb slowly as
  // Kruskal expects; about one in twenty breaks the order on purpose.
  task automatic offer_edge(input logic [VTX_IN_W-1:0] va, input logic [VTX_IN_W-1:0] vb,
                            input int max_step);
    int bump;
    bump = $urandom_range(0, max_step);
    if ($urandom_range(0, 19) == 0) begin
      send_cmd(CMD_EDGE, va, vb, WEIGHT_W'($urandom_range(0, 65535)));
    end else begin
      if (int'(edge_weight) + bump > 65535) edge_weight = '1;
      else edge_weight = edge_weight + WEIGHT_W'(bump);
      send_cmd(CMD_EDGE, va, vb, edge_weight);
    end
  endtask

  // Sprinkles finds into a sequence, and now and then a fully random
  // transaction (any command, any fields) that may break the sequence.
  task automatic side_traffic(input int base, input int stride, input int pool);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_cmd(CMD_FIND, spread(base, stride, $urandom_range(0, pool - 1)),
               VTX_IN_W'($urandom_range(0, 255)), WEIGHT_W'($urandom_range(0, 65535)));
    end else if (pick < 24) begin
      send_cmd(2'($urandom_range(0, 3)), VTX_IN_W'($urandom_range(0, 255)),
               VTX_IN_W'($urandom_range(0, 255)), WEIGHT_W'($urandom_range(0, 65535)));
    end
  endtask

  // One episode: usually a clear, then a well-formed edge sequence over a
  // scattered pool of vertices. Pairwise tournaments build the tallest trees
  // that union by rank allows; random pairs mix merges with edges that fall
  // inside one set and with every rank relation.
  task automatic run_episode();
    int base;
    int stride;
    int pool;
    int span;
    int count;
    int max_step;
    base     = $urandom_range(0, 255);
    stride   = 2 * $urandom_range(0, 127) + 1;
    max_step = $urandom_range(0, 1) ? 3 : 900;
    edge_weight = WEIGHT_W'($urandom_range(0, 40000));
    if ($urandom_range(0, 4) != 0) begin
      send_cmd(CMD_CLEAR, VTX_IN_W'($urandom_range(0, 255)), VTX_IN_W'($urandom_range(0, 255)),
               WEIGHT_W'($urandom_range(0, 65535)));
    end
    if ($urandom_range(0, 2) == 0) begin
      pool = 1 << $urandom_range(2, 5);
      for (span = 1; span < pool; span = span * 2) begin
        for (int i = 0; i + span < pool; i += 2 * span) begin
          side_traffic(base, stride, pool);
          if ($urandom_range(0, 1)) begin
            offer_edge(spread(base, stride, i), spread(base, stride, i + span), max_step);
          end else begin
            offer_edge(spread(base, stride, i + span), spread(base, stride, i), max_step);
          end
        end
      end
      // The last leaf hangs at the bottom of the tallest chain.
      send_cmd(CMD_FIND, spread(base, stride, pool - 1), VTX_IN_W'($urandom_range(0, 255)),
               WEIGHT_W'($urandom_range(0, 65535)));
    end else begin
      pool  = 4 << (2 * $urandom_range(0, 3));
      count = $urandom_range(10, 40);
      for (int j = 0; j < count; j++) begin
        side_traffic(base, stride, pool);
        offer_edge(spread(base, stride, $urandom_range(0, pool - 1)),
                   spread(base, stride, $urandom_range(0, pool - 1)), max_step);
      end
    end
  endtask

  initial begin
    int phase_goal;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_command  <= CMD_CLEAR;
    in_vertex_a <= '0;
    in_vertex_b <= '0;
    in_weight   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The block sweeps its table after reset with busy high,
    // so the first transaction simply waits for busy to drop.
    send_cmd(CMD_FIND, 8'd0, 8'd255, 16'h0000);
    send_cmd(CMD_FIND, 8'd255, 8'd0, 16'hFFFF);
    // Equal ranks: the lowest and highest vertex join under vertex_a's root.
    send_cmd(CMD_EDGE, 8'd0, 8'd255, 16'd0);
    // Reversed edge inside the same set: not accepted, cost unchanged.
    send_cmd(CMD_EDGE, 8'd255, 8'd0, 16'd1);
    send_cmd(CMD_EDGE, 8'd1, 8'd2, 16'hFFFF);
    // Two rank-one roots meet, so the surviving root climbs to rank two.
    send_cmd(CMD_EDGE, 8'd0, 8'd1, 16'hFFFF);
    // Lower rank on the vertex_a side: vertex_a's root goes under the other.
    send_cmd(CMD_EDGE, 8'd3, 8'd0, 16'hFFFF);
    // Higher rank on the vertex_a side: vertex_b's root goes under it.
    send_cmd(CMD_EDGE, 8'd0, 8'd4, 16'hFFFF);
    send_cmd(CMD_FIND, 8'd2, 8'd0, 16'd0);
    send_cmd(CMD_FIND, 8'd255, 8'd0, 16'd0);
    // Self loop: both endpoints already share a root.
    send_cmd(CMD_EDGE, 8'd7, 8'd7, 16'h1234);
    // Unused command encoding: no state change, current cost is reported.
    send_cmd(CMD_UNUSED, 8'hAA, 8'h55, 16'hA5A5);
    send_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
    // Clear with every field set, then confirm the old tree is gone.
    send_cmd(CMD_CLEAR, 8'hFF, 8'hFF, 16'hFFFF);
    send_cmd(CMD_FIND, 8'd2, 8'd0, 16'd0);
    send_cmd(CMD_EDGE, 8'h55, 8'hAA, 16'h5A5A);
    send_cmd(CMD_EDGE, 8'hAA, 8'h55, 16'h5A5A);
    send_cmd(CMD_FIND, 8'hAA, 8'h00, 16'h0000);

    // The sender waits here until the block has answered everything.
    drain_results();

    // Random part in three phases: light sender idling, heavy sender idling,
    // then back-to-back transactions. The result side cannot be stalled.
    sender_idle_pct = 12;
    phase_goal = items_sent + 150;
    while (items_sent < phase_goal) run_episode();
    drain_results();

    sender_idle_pct = 56;
    phase_goal = items_sent + 150;
    while (items_sent < phase_goal) run_episode();
    drain_results();

    sender_idle_pct = 0;
    phase_goal = items_sent + 150;
    while (items_sent < phase_goal) run_episode();

    // Every transaction yields one result, so once none is pending only a
    // short tail is needed to catch a stray extra strobe.
    drain_results();
    repeat (32) @(posedge clk);

    $display("Covered %0d clears, %0d finds, %0d edge offers (%0d joined two sets), %0d unused.",
             clears_sent, finds_sent, edges_sent, joined_count, unused_sent);
    $display("Longest root walk was %0d links; sender idled at 12, 56 and 0 percent.",
             deepest_walk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net: the slowest correct run (a clear sweep on every transaction
  // plus the heaviest idling) stays well below this.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
